// ----- sv/cpnr_pkg.sv -----
package cpnr_pkg;

    localparam int MAX_ORDER_DEF = 64;
    localparam logic [31:0] TWO_PI_Q16 = 32'd411775;

    typedef struct packed {
        logic [31:0]        modulus;
        logic signed [31:0] argument;
        logic [6:0]         root_order;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        root_modulus;
        logic signed [31:0] root_argument;
        logic [5:0]         root_index;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_MUL,
        ST_MULEND,
        ST_CMP,
        ST_DIVINIT,
        ST_DIV,
        ST_DIVFIX,
        ST_EMIT
    } state_t;

endpackage

// ----- sv/cpnr_sermul.sv -----
// Bit-serial 32x32 multiplier: one multiplier bit per cycle, saturating Q20.12 result.
module cpnr_sermul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] prod
);
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mb_reg, mb_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] sum;

    // Add the shifted multiplicand into the upper half, then shift right
    always_comb
    begin
        sum       = {1'b0, acc_reg[63:32]} + {1'b0, (mb_reg[0] ? a : 32'd0)};
        acc_next  = acc_reg;
        mb_next   = mb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            mb_next   = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = {sum, acc_reg[31:1]};
            mb_next   = {1'b0, mb_reg[31:1]};
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mb_reg  <= mb_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd31);
    // Saturate when any bit above the Q20.12 window is set (valid on the cycle after done)
    assign prod = (|acc_reg[63:44]) ? 32'hFFFF_FFFF : acc_reg[43:12];
endmodule

// ----- sv/complex_polar_nth_roots.sv -----
// Operation: up to 32 trial bits, each needing (n-1) serial multiplies, then
// per root a 40-bit restoring divide.
// Throughput: one input transaction at a time; next accepted after the last root leaves.
// The multiplier is bit-serial (one bit per cycle) and the divider is serial.
// Reset (rst_n, asynchronous, active low) returns to idle with no result pending.
module complex_polar_nth_roots
#(
    parameter int MAX_ORDER = cpnr_pkg::MAX_ORDER_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cpnr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cpnr_pkg::out_item_t out_data
);
    import cpnr_pkg::*;

    localparam int NW = $clog2(MAX_ORDER + 1);

    state_t state_reg, state_next;

    logic [31:0]  m_reg, m_next;
    logic signed [31:0] arg_reg, arg_next;
    logic [NW-1:0] n_reg, n_next;
    logic [31:0]  r_reg, r_next;
    logic [31:0]  t_reg, t_next;
    logic [31:0]  pw_reg, pw_next;
    logic [4:0]   bit_reg, bit_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] k_reg, k_next;
    logic signed [39:0] s_reg, s_next;
    logic [39:0]  q_reg, q_next;
    logic [NW:0]  rem_reg, rem_next;
    logic         neg_reg, neg_next;
    logic [5:0]   dc_reg, dc_next;
    logic         ov_reg, ov_next;
    out_item_t    ob_reg, ob_next;

    logic        mul_start, mul_done;
    logic [31:0] mul_prod;
    logic [NW-1:0] n_in;
    logic [NW:0] rem_sh;
    logic [39:0] s_abs;
    logic [31:0] q_sgn;

    cpnr_sermul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (pw_reg),
        .b     (t_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Clamp the order to MAX_ORDER
    always_comb
    begin
        if (in_data.root_order > 7'(MAX_ORDER))
            n_in = NW'(MAX_ORDER);
        else
            n_in = NW'(in_data.root_order);
    end

    assign rem_sh = {rem_reg[NW-1:0], q_reg[39]};
    assign s_abs  = s_reg[39] ? 40'(-s_reg) : 40'(s_reg);
    assign q_sgn  = neg_reg ? 32'(-q_reg[31:0]) : q_reg[31:0];

    // Sequence root search, then one serial divide per root
    always_comb
    begin
        state_next = state_reg;
        m_next = m_reg; arg_next = arg_reg; n_next = n_reg;
        r_next = r_reg; t_next = t_reg; pw_next = pw_reg;
        bit_next = bit_reg; i_next = i_reg; k_next = k_reg;
        s_next = s_reg; q_next = q_reg; rem_next = rem_reg;
        neg_next = neg_reg; dc_next = dc_reg; ov_next = ov_reg; ob_next = ob_reg;
        mul_start = 1'b0;
        in_stall  = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_data.root_order != 7'd0)
                begin
                    m_next   = in_data.modulus;
                    arg_next = in_data.argument;
                    n_next   = n_in;
                    r_next   = '0;
                    bit_next = 5'd31;
                    state_next = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                t_next  = r_reg | (32'd1 << bit_reg);
                pw_next = r_reg | (32'd1 << bit_reg);
                i_next  = NW'(1);
                state_next = ST_MULEND;
            end
            ST_MULEND:
            begin
                // Chain another multiply while fewer than n factors
                if (i_reg < n_reg)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
                else
                    state_next = ST_CMP;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    ov_next = 1'b1;
                    state_next = ST_DIVFIX;
                end
            end
            ST_DIVFIX:
            begin
                if (ov_reg)
                begin
                    // Product register settled: take it
                    pw_next = mul_prod;
                    i_next  = i_reg + NW'(1);
                    ov_next = 1'b0;
                    state_next = ST_MULEND;
                end
                else
                begin
                    ob_next.root_modulus  = r_reg;
                    ob_next.root_argument = q_sgn;
                    ob_next.root_index    = 6'(k_reg);
                    ob_next.last          = (k_reg + NW'(1) == n_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_CMP:
            begin
                if (pw_reg <= m_reg)
                    r_next = t_reg;
                if (bit_reg == 5'd0)
                begin
                    k_next = '0;
                    state_next = ST_DIVINIT;
                end
                else
                begin
                    bit_next = bit_reg - 5'd1;
                    state_next = ST_TRIAL;
                end
            end
            ST_DIVINIT:
            begin
                s_next = 40'(arg_reg) + 40'(k_reg) * 40'(TWO_PI_Q16);
                state_next = ST_DIV;
                dc_next = '0;
                rem_next = '0;
                ov_next = 1'b0;
                neg_next = 1'b0;
            end
            ST_DIV:
            begin
                // Load magnitude on first step, then one quotient bit per cycle
                if (dc_reg == 6'd0)
                begin
                    neg_next = s_reg[39];
                    q_next   = s_abs;
                    dc_next  = 6'd1;
                end
                else
                begin
                    if (rem_sh >= {1'b0, n_reg})
                    begin
                        rem_next = rem_sh - {1'b0, n_reg};
                        q_next   = {q_reg[38:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next   = {q_reg[38:0], 1'b0};
                    end
                    dc_next = dc_reg + 6'd1;
                    if (dc_reg == 6'd40)
                        state_next = ST_DIVFIX;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (ob_reg.last)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next = k_reg + NW'(1);
                        state_next = ST_DIVINIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next; arg_reg <= arg_next; n_reg <= n_next;
        r_reg <= r_next; t_reg <= t_next; pw_reg <= pw_next;
        bit_reg <= bit_next; i_reg <= i_next; k_reg <= k_next;
        s_reg <= s_next; q_reg <= q_next; rem_reg <= rem_next;
        neg_reg <= neg_next; dc_reg <= dc_next; ov_reg <= ov_next; ob_reg <= ob_next;
    end

    assign out_valid = (state_reg == ST_EMIT);
    assign out_data  = ob_reg;
endmodule
